FILE: rtl/jac_pkg.sv
// Shared types and constants for the joystick axis conditioner.
`default_nettype none
package jac_pkg;

    localparam int RAW_W = 12;   // ADC sample and center width
    localparam int OUT_W = 13;   // signed result width
    localparam int DIV_W = 13;   // divisor magnitude width (up to 4096)
    localparam int CFG_W = 13;   // config write data width
    localparam int IDX_W = 3;    // config register index width

    typedef enum logic [1:0] {
        OP_SIMPLE  = 2'd0,
        OP_GAMEPAD = 2'd1,
        OP_MOUSE   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [RAW_W-1:0]        rest_x;
        logic [RAW_W-1:0]        rest_y;
        logic [RAW_W-1:0]        deadzone_x;
        logic [RAW_W-1:0]        deadzone_y;
        logic signed [CFG_W-1:0] span_x_neg;
        logic [RAW_W-1:0]        span_x_pos;
        logic signed [CFG_W-1:0] span_y_neg;
        logic [RAW_W-1:0]        span_y_pos;
    } cfg_t;

    // Side data that rides along the divider chain.
    typedef struct packed {
        logic                    scaled;   // gamepad result comes from divider
        logic                    neg_x;    // negate x quotient
        logic                    neg_y;
        logic                    dzero_x;  // x divisor is zero
        logic                    dzero_y;
        logic signed [OUT_W-1:0] byp_x;    // result when not scaled
        logic signed [OUT_W-1:0] byp_y;
    } side_t;

endpackage
`default_nettype wire

FILE: rtl/jac_prep.sv
// Centering, deadzone test and divider operand setup, two pipeline stages.
`default_nettype none
module jac_prep #(
    parameter int ADC_BITS      = 12,
    parameter int GAMEPAD_LIMIT = 127,
    parameter int MOUSE_LIMIT   = 2047,
    parameter int DW            = 19
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire jac_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire jac_pkg::op_t                  in_opcode,
    input  wire logic [jac_pkg::RAW_W-1:0]     in_raw_x,
    input  wire logic [jac_pkg::RAW_W-1:0]     in_raw_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output jac_pkg::side_t                     out_side,
    output logic [DW-1:0]                      out_dvd_x,
    output logic [jac_pkg::DIV_W-1:0]          out_div_x,
    output logic [DW-1:0]                      out_dvd_y,
    output logic [jac_pkg::DIV_W-1:0]          out_div_y
);
    import jac_pkg::*;

    localparam int RAW_KEEP = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((32'd1 << RAW_KEEP) - 32'd1);
    localparam int LW = $clog2(GAMEPAD_LIMIT + 1);
    localparam logic [LW-1:0] LIM = LW'(GAMEPAD_LIMIT);
    localparam int MW = 17;
    localparam logic signed [MW-1:0] MHI = MW'(MOUSE_LIMIT);
    localparam logic signed [MW-1:0] MLO = -MHI - MW'(1);

    // stage 1: centered samples
    logic                    p1_valid_reg;
    logic                    p1_ready;
    op_t                     op_reg;
    logic signed [OUT_W-1:0] x_reg, y_reg;
    logic signed [OUT_W-1:0] x_next, y_next;

    // stage 2
    logic                    p2_ready;
    logic signed [OUT_W-1:0] negx, negy;
    logic [RAW_W-1:0]        mag_x, mag_y;
    logic                    in_x, in_y, box, pos_x, pos_y;
    logic signed [CFG_W-1:0] nsx, nsy;
    logic [DIV_W-1:0]        div_x, div_y;
    logic signed [MW-1:0]    mv_x, mv_y;
    logic signed [MW-1:0]    mc_x, mc_y;
    side_t                   side_next;

    assign p2_ready = !out_valid || out_ready;
    assign p1_ready = !p1_valid_reg || p2_ready;
    assign in_ready = p1_ready;

    assign x_next = $signed({1'b0, in_raw_x & RAW_MASK}) - $signed({1'b0, cfg.rest_x});
    assign y_next = $signed({1'b0, in_raw_y & RAW_MASK}) - $signed({1'b0, cfg.rest_y});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p1_valid_reg <= in_valid;
        end
        if (p1_ready && in_valid) begin
            op_reg <= in_opcode;
            x_reg  <= x_next;
            y_reg  <= y_next;
        end
    end

    always_comb begin
        negx  = -x_reg;
        negy  = -y_reg;
        mag_x = x_reg[OUT_W-1] ? negx[RAW_W-1:0] : x_reg[RAW_W-1:0];
        mag_y = y_reg[OUT_W-1] ? negy[RAW_W-1:0] : y_reg[RAW_W-1:0];
        in_x  = mag_x < cfg.deadzone_x;
        in_y  = mag_y < cfg.deadzone_y;
        box   = in_x && in_y;
        pos_x = !x_reg[OUT_W-1] && (x_reg != '0);
        pos_y = !y_reg[OUT_W-1] && (y_reg != '0);

        nsx   = -cfg.span_x_neg;
        nsy   = -cfg.span_y_neg;
        // magnitude of the chosen divisor; -4096 negates to 4096 unsigned
        div_x = pos_x ? {1'b0, cfg.span_x_pos}
                      : (cfg.span_x_neg[CFG_W-1] ? DIV_W'(nsx) : DIV_W'(cfg.span_x_neg));
        div_y = pos_y ? {1'b0, cfg.span_y_pos}
                      : (cfg.span_y_neg[CFG_W-1] ? DIV_W'(nsy) : DIV_W'(cfg.span_y_neg));

        mv_x = box ? '0 : {{(MW-OUT_W){negx[OUT_W-1]}}, negx};
        mv_y = box ? '0 : {{(MW-OUT_W){negy[OUT_W-1]}}, negy};
        mc_x = (mv_x > MHI) ? MHI : ((mv_x < MLO) ? MLO : mv_x);
        mc_y = (mv_y > MHI) ? MHI : ((mv_y < MLO) ? MLO : mv_y);

        side_next         = '0;
        side_next.neg_x   = pos_x || (!cfg.span_x_neg[CFG_W-1] && (cfg.span_x_neg != '0));
        side_next.neg_y   = pos_y || (!cfg.span_y_neg[CFG_W-1] && (cfg.span_y_neg != '0));
        side_next.dzero_x = (div_x == '0);
        side_next.dzero_y = (div_y == '0);
        unique case (op_reg)
            OP_SIMPLE: begin
                side_next.byp_x = in_x ? '0 : negx;
                side_next.byp_y = in_y ? '0 : negy;
            end
            OP_GAMEPAD: begin
                side_next.scaled = !box;
            end
            OP_MOUSE: begin
                side_next.byp_x = mc_x[OUT_W-1:0];
                side_next.byp_y = mc_y[OUT_W-1:0];
            end
            default: begin
                side_next.byp_x = '0;
                side_next.byp_y = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (p2_ready) begin
            out_valid <= p1_valid_reg;
        end
        if (p2_ready && p1_valid_reg) begin
            out_side  <= side_next;
            out_dvd_x <= DW'(mag_x) * DW'(LIM);
            out_dvd_y <= DW'(mag_y) * DW'(LIM);
            out_div_x <= div_x;
            out_div_y <= div_y;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jac_div_cell.sv
// One restoring-division cell: one quotient bit per axis per word.
`default_nettype none
module jac_div_cell #(
    parameter int DW = 19,
    parameter int DV = 13
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire jac_pkg::side_t in_side,
    input  wire logic [DV-1:0]  in_rem_x,
    input  wire logic [DW-1:0]  in_aq_x,
    input  wire logic [DV-1:0]  in_div_x,
    input  wire logic [DV-1:0]  in_rem_y,
    input  wire logic [DW-1:0]  in_aq_y,
    input  wire logic [DV-1:0]  in_div_y,
    output logic                out_valid,
    input  wire logic           out_ready,
    output jac_pkg::side_t      out_side,
    output logic [DV-1:0]       out_rem_x,
    output logic [DW-1:0]       out_aq_x,
    output logic [DV-1:0]       out_div_x,
    output logic [DV-1:0]       out_rem_y,
    output logic [DW-1:0]       out_aq_y,
    output logic [DV-1:0]       out_div_y
);
    import jac_pkg::*;

    logic [DV:0]   trial_x, trial_y;
    logic [DV:0]   diff_x, diff_y;
    logic          ge_x, ge_y;

    assign in_ready = !out_valid || out_ready;

    // aq shifts the dividend out at the top and the quotient in at the bottom
    always_comb begin
        trial_x = {in_rem_x, in_aq_x[DW-1]};
        trial_y = {in_rem_y, in_aq_y[DW-1]};
        diff_x  = trial_x - {1'b0, in_div_x};
        diff_y  = trial_y - {1'b0, in_div_y};
        ge_x    = trial_x >= {1'b0, in_div_x};
        ge_y    = trial_y >= {1'b0, in_div_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (in_ready) begin
            out_valid <= in_valid;
        end
        if (in_ready && in_valid) begin
            out_side  <= in_side;
            out_rem_x <= ge_x ? diff_x[DV-1:0] : trial_x[DV-1:0];
            out_rem_y <= ge_y ? diff_y[DV-1:0] : trial_y[DV-1:0];
            out_aq_x  <= {in_aq_x[DW-2:0], ge_x};
            out_aq_y  <= {in_aq_y[DW-2:0], ge_y};
            out_div_x <= in_div_x;
            out_div_y <= in_div_y;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jac_skid.sv
// Two-entry output skid buffer feeding the result stream.
`default_nettype none
module jac_skid #(
    parameter int W = 26
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    logic         main_valid_reg;
    logic [W-1:0] main_data_reg;
    logic         spare_valid_reg;
    logic [W-1:0] spare_data_reg;

    assign in_ready  = !spare_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            if (spare_valid_reg) begin
                main_valid_reg  <= 1'b1;
                main_data_reg   <= spare_data_reg;
                spare_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
                main_data_reg  <= in_data;
            end
        end else if (in_valid && in_ready) begin
            spare_valid_reg <= 1'b1;
            spare_data_reg  <= in_data;
        end
    end

    a_spare_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> main_valid_reg)
        else $error("skid spare holds a word while main is empty");

    a_spare_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(spare_valid_reg) |-> $past(main_valid_reg && !out_ready))
        else $error("skid spare filled without an output stall");

    a_spare_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (spare_valid_reg && out_ready) |=> (main_valid_reg && !spare_valid_reg))
        else $error("skid spare word not promoted after output handshake");

endmodule
`default_nettype wire

FILE: rtl/joystick_axis_conditioner_unit.sv
// Top level: config registers, prep stages, divider cell chain, clamp and skid.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata: opcode, raw_x, raw_y
//  m_*       out        m_tvalid / m_tready  m_tdata: out_x, out_y
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while m_tready stays high. Words pass through two
// prep stages, one restoring-divider cell per quotient bit and the output skid,
// with DW = clog2(GAMEPAD_LIMIT+1) + 12. Reset clears all valid flags and
// loads the calibration defaults. A stalled stage holds while later ones
// still drain; the output skid takes one more word while m_tready is low.
`default_nettype none
module joystick_axis_conditioner_unit #(
    parameter int ADC_BITS      = 12,
    parameter int GAMEPAD_LIMIT = 127,
    parameter int MOUSE_LIMIT   = 2047
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // opcode[1:0], raw_x[13:2], raw_y[25:14]
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [31:0]                      m_tdata,   // out_x[12:0], out_y[25:13]
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [jac_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [jac_pkg::CFG_W-1:0]   cfg_data
);
    import jac_pkg::*;

    localparam int LW = $clog2(GAMEPAD_LIMIT + 1);
    localparam int DW = LW + RAW_W;
    localparam logic [DW-1:0] LIM_DW = DW'(GAMEPAD_LIMIT);
    localparam int SW = 2 * OUT_W;

    localparam logic [IDX_W-1:0] REG_REST_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_REST_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_DEADZONE_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_DEADZONE_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPAN_X_NEG = 3'd4;
    localparam logic [IDX_W-1:0] REG_SPAN_X_POS = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPAN_Y_NEG = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPAN_Y_POS = 3'd7;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rest_x     <= RAW_W'(2048);
            cfg_reg.rest_y     <= RAW_W'(2048);
            cfg_reg.deadzone_x <= '0;
            cfg_reg.deadzone_y <= '0;
            cfg_reg.span_x_neg <= -CFG_W'(2048);
            cfg_reg.span_x_pos <= RAW_W'(2047);
            cfg_reg.span_y_neg <= -CFG_W'(2048);
            cfg_reg.span_y_pos <= RAW_W'(2047);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_REST_X:     cfg_reg.rest_x     <= cfg_data[RAW_W-1:0];
                REG_REST_Y:     cfg_reg.rest_y     <= cfg_data[RAW_W-1:0];
                REG_DEADZONE_X: cfg_reg.deadzone_x <= cfg_data[RAW_W-1:0];
                REG_DEADZONE_Y: cfg_reg.deadzone_y <= cfg_data[RAW_W-1:0];
                REG_SPAN_X_NEG: cfg_reg.span_x_neg <= $signed(cfg_data);
                REG_SPAN_X_POS: cfg_reg.span_x_pos <= cfg_data[RAW_W-1:0];
                REG_SPAN_Y_NEG: cfg_reg.span_y_neg <= $signed(cfg_data);
                REG_SPAN_Y_POS: cfg_reg.span_y_pos <= cfg_data[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // chain links: index 0 is the prep output, index DW the last cell output
    logic [DW:0]      vld;
    logic [DW:0]      rdy;
    side_t            side   [DW+1];
    logic [DIV_W-1:0] rem_x  [DW+1];
    logic [DIV_W-1:0] rem_y  [DW+1];
    logic [DW-1:0]    aq_x   [DW+1];
    logic [DW-1:0]    aq_y   [DW+1];
    logic [DIV_W-1:0] dv_x   [DW+1];
    logic [DIV_W-1:0] dv_y   [DW+1];

    assign rem_x[0] = '0;
    assign rem_y[0] = '0;

    jac_prep #(
        .ADC_BITS      (ADC_BITS),
        .GAMEPAD_LIMIT (GAMEPAD_LIMIT),
        .MOUSE_LIMIT   (MOUSE_LIMIT),
        .DW            (DW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (op_t'(s_tdata[1:0])),
        .in_raw_x  (s_tdata[13:2]),
        .in_raw_y  (s_tdata[25:14]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_side  (side[0]),
        .out_dvd_x (aq_x[0]),
        .out_div_x (dv_x[0]),
        .out_dvd_y (aq_y[0]),
        .out_div_y (dv_y[0])
    );

    for (genvar i = 0; i < DW; i++) begin : g_cell
        jac_div_cell #(
            .DW (DW),
            .DV (DIV_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_side   (side[i]),
            .in_rem_x  (rem_x[i]),
            .in_aq_x   (aq_x[i]),
            .in_div_x  (dv_x[i]),
            .in_rem_y  (rem_y[i]),
            .in_aq_y   (aq_y[i]),
            .in_div_y  (dv_y[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_side  (side[i+1]),
            .out_rem_x (rem_x[i+1]),
            .out_aq_x  (aq_x[i+1]),
            .out_div_x (dv_x[i+1]),
            .out_rem_y (rem_y[i+1]),
            .out_aq_y  (aq_y[i+1]),
            .out_div_y (dv_y[i+1])
        );
    end

    // clamp quotient magnitude to the limit, apply sign, pick bypass result
    logic [DW-1:0]           qm_x, qm_y;
    logic signed [DW:0]      qs_x, qs_y;
    logic signed [OUT_W-1:0] res_x, res_y;
    side_t                   tail;

    always_comb begin
        tail = side[DW];
        qm_x = (aq_x[DW] > LIM_DW) ? LIM_DW : aq_x[DW];
        qm_y = (aq_y[DW] > LIM_DW) ? LIM_DW : aq_y[DW];
        qs_x = tail.neg_x ? -$signed({1'b0, qm_x}) : $signed({1'b0, qm_x});
        qs_y = tail.neg_y ? -$signed({1'b0, qm_y}) : $signed({1'b0, qm_y});
        if (tail.scaled) begin
            res_x = tail.dzero_x ? '0 : qs_x[OUT_W-1:0];
            res_y = tail.dzero_y ? '0 : qs_y[OUT_W-1:0];
        end else begin
            res_x = tail.byp_x;
            res_y = tail.byp_y;
        end
    end

    logic [SW-1:0] skid_out;

    jac_skid #(
        .W (SW)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[DW]),
        .in_ready  (rdy[DW]),
        .in_data   ({res_y, res_x}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (skid_out)
    );

    assign m_tdata = {(32 - SW)'(0), skid_out};

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for joystick_axis_conditioner_unit: table, calibration sweeps, random.
module testbench;
    import jac_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     DRAIN_WAIT  = 40;     // well past the pipeline depth
    localparam longint PAD_LIM     = 127;
    localparam longint MOUSE_LIM   = 2047;

    typedef enum logic [IDX_W-1:0] {
        REG_REST_X     = 3'd0,
        REG_REST_Y     = 3'd1,
        REG_DEADZONE_X = 3'd2,
        REG_DEADZONE_Y = 3'd3,
        REG_SPAN_X_NEG = 3'd4,
        REG_SPAN_X_POS = 3'd5,
        REG_SPAN_Y_NEG = 3'd6,
        REG_SPAN_Y_POS = 3'd7
    } cal_reg_t;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } stick_out_t;

    typedef struct {
        op_t              op;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        bit               known;
        logic [OUT_W-1:0] want_x;
        logic [OUT_W-1:0] want_y;
    } stick_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;   // opcode[1:0], raw_x[13:2], raw_y[25:14]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;          // out_x[12:0], out_y[25:13]
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // calibration as the block should hold it
    longint cal_rest_x     = 2048;
    longint cal_rest_y     = 2048;
    longint cal_deadzone_x = 0;
    longint cal_deadzone_y = 0;
    longint cal_span_x_neg = -2048;
    longint cal_span_x_pos = 2047;
    longint cal_span_y_neg = -2048;
    longint cal_span_y_pos = 2047;

    stick_out_t pending_sticks[$];
    int         errors     = 0;
    int         cycles     = 0;
    int         ready_hold = 0;
    bit         calm       = 1'b0;
    stick_out_t got_word;
    stick_out_t want_word;

    // reset calibration: center 2048, no deadzone, spans -2048 / 2047
    stick_row_t directed_rows [16] = '{
        '{OP_SIMPLE,  12'd2048, 12'd2048, 1'b1, 13'd0,      13'd0},
        '{OP_SIMPLE,  12'd0,    12'd4095, 1'b1, 13'd2048,   -13'sd2047},
        '{OP_SIMPLE,  12'd4095, 12'd0,    1'b1, -13'sd2047, 13'd2048},
        '{OP_GAMEPAD, 12'd2048, 12'd2048, 1'b1, 13'd0,      13'd0},
        '{OP_GAMEPAD, 12'd0,    12'd4095, 1'b1, 13'd127,    -13'sd127},
        '{OP_GAMEPAD, 12'd4095, 12'd0,    1'b1, -13'sd127,  13'd127},
        '{OP_MOUSE,   12'd0,    12'd4095, 1'b1, 13'd2047,   -13'sd2047},
        '{OP_MOUSE,   12'd4095, 12'd0,    1'b1, -13'sd2047, 13'd2047},
        '{OP_MOUSE,   12'd2048, 12'd2048, 1'b1, 13'd0,      13'd0},
        '{OP_NONE,    12'd0,    12'd4095, 1'b1, 13'd0,      13'd0},
        '{OP_NONE,    12'd4095, 12'd4095, 1'b1, 13'd0,      13'd0},
        '{OP_SIMPLE,  12'd1000, 12'd3000, 1'b0, 13'd0,      13'd0},
        '{OP_GAMEPAD, 12'd1500, 12'd2600, 1'b0, 13'd0,      13'd0},
        '{OP_GAMEPAD, 12'd2049, 12'd2047, 1'b0, 13'd0,      13'd0},
        '{OP_MOUSE,   12'd100,  12'd4000, 1'b0, 13'd0,      13'd0},
        '{OP_GAMEPAD, 12'd1024, 12'd3071, 1'b0, 13'd0,      13'd0}
    };

    joystick_axis_conditioner_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic bit in_deadzone(longint v, longint dz);
        longint mag;
        mag = (v < 0) ? -v : v;
        return mag < dz;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // divide truncates toward zero; a zero span gives zero
    function automatic longint scale_to_pad(longint v, longint span_neg, longint span_pos);
        longint q;
        if (v > 0)
            q = (span_pos == 0) ? 0 : (-PAD_LIM * v) / span_pos;
        else
            q = (span_neg == 0) ? 0 : (PAD_LIM * v) / span_neg;
        return clamp(q, -PAD_LIM, PAD_LIM);
    endfunction

    function automatic stick_out_t condition_stick(op_t op, logic [RAW_W-1:0] raw_x,
                                                   logic [RAW_W-1:0] raw_y);
        longint     x;
        longint     y;
        longint     ox;
        longint     oy;
        bit         in_box;
        stick_out_t r;
        x = longint'(raw_x) - cal_rest_x;
        y = longint'(raw_y) - cal_rest_y;
        ox = 0;
        oy = 0;
        in_box = in_deadzone(x, cal_deadzone_x) && in_deadzone(y, cal_deadzone_y);
        case (op)
            OP_SIMPLE: begin
                ox = in_deadzone(x, cal_deadzone_x) ? 0 : -x;
                oy = in_deadzone(y, cal_deadzone_y) ? 0 : -y;
            end
            OP_GAMEPAD: begin
                if (!in_box) begin
                    ox = scale_to_pad(x, cal_span_x_neg, cal_span_x_pos);
                    oy = scale_to_pad(y, cal_span_y_neg, cal_span_y_pos);
                end
            end
            OP_MOUSE: begin
                if (!in_box) begin
                    ox = -x;
                    oy = -y;
                end
                ox = clamp(ox, -MOUSE_LIM - 1, MOUSE_LIM);
                oy = clamp(oy, -MOUSE_LIM - 1, MOUSE_LIM);
            end
            default: ;
        endcase
        r.x = ox[OUT_W-1:0];
        r.y = oy[OUT_W-1:0];
        return r;
    endfunction

    function automatic void note_cal(cal_reg_t idx, logic [CFG_W-1:0] d);
        case (idx)
            REG_REST_X:     cal_rest_x     = longint'(d[RAW_W-1:0]);
            REG_REST_Y:     cal_rest_y     = longint'(d[RAW_W-1:0]);
            REG_DEADZONE_X: cal_deadzone_x = longint'(d[RAW_W-1:0]);
            REG_DEADZONE_Y: cal_deadzone_y = longint'(d[RAW_W-1:0]);
            REG_SPAN_X_NEG: cal_span_x_neg = longint'($signed(d));
            REG_SPAN_X_POS: cal_span_x_pos = longint'(d[RAW_W-1:0]);
            REG_SPAN_Y_NEG: cal_span_y_neg = longint'($signed(d));
            REG_SPAN_Y_POS: cal_span_y_pos = longint'(d[RAW_W-1:0]);
            default: ;
        endcase
    endfunction

    // sample close to a center so the deadzone edges get hit
    function automatic logic [RAW_W-1:0] near_center(longint center, longint dz);
        longint reach;
        longint v;
        reach = (dz > 1000 ? 1000 : dz) + 8;
        v = center + longint'($urandom_range(0, 2 * reach)) - reach;
        return RAW_W'(clamp(v, 0, 4095));
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_sticks.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cal(cal_reg_t idx, logic [CFG_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        note_cal(idx, d);
    endtask

    task automatic calibrate(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                             logic [CFG_W-1:0] dx, logic [CFG_W-1:0] dy,
                             logic [CFG_W-1:0] xn, logic [CFG_W-1:0] xp,
                             logic [CFG_W-1:0] yn, logic [CFG_W-1:0] yp);
        wait_idle();
        write_cal(REG_REST_X, cx);
        write_cal(REG_REST_Y, cy);
        write_cal(REG_DEADZONE_X, dx);
        write_cal(REG_DEADZONE_Y, dy);
        write_cal(REG_SPAN_X_NEG, xn);
        write_cal(REG_SPAN_X_POS, xp);
        write_cal(REG_SPAN_Y_NEG, yn);
        write_cal(REG_SPAN_Y_POS, yp);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_stick(op_t op, logic [RAW_W-1:0] raw_x, logic [RAW_W-1:0] raw_y,
                              bit known, logic [OUT_W-1:0] want_x, logic [OUT_W-1:0] want_y);
        int         gap;
        stick_out_t want;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, raw_y, raw_x, op};
        do @(posedge aclk); while (!s_tready);
        if (known) begin
            want.x = want_x;
            want.y = want_y;
        end else begin
            want = condition_stick(op, raw_x, raw_y);
        end
        pending_sticks.push_back(want);
    endtask

    task automatic send_random_sticks(int count, bit hold_midway);
        op_t              op;
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        for (int i = 0; i < count; i++) begin
            if (hold_midway && i == count / 2)
                wait_idle();
            op = ($urandom_range(0, 9) == 0) ? OP_NONE : op_t'($urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0) begin
                rx = near_center(cal_rest_x, cal_deadzone_x);
                ry = near_center(cal_rest_y, cal_deadzone_y);
            end else begin
                rx = RAW_W'($urandom_range(0, 4095));
                ry = RAW_W'($urandom_range(0, 4095));
            end
            send_stick(op, rx, ry, 1'b0, '0, '0);
        end
    endtask

    task automatic random_calibration();
        logic [CFG_W-1:0] cx;
        logic [CFG_W-1:0] cy;
        logic [CFG_W-1:0] dx;
        logic [CFG_W-1:0] dy;
        logic [CFG_W-1:0] xn;
        logic [CFG_W-1:0] yn;
        cx = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1500, 2600))
                                         : CFG_W'($urandom_range(0, 8191));
        cy = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1500, 2600))
                                         : CFG_W'($urandom_range(0, 8191));
        dx = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 8191))
                                         : CFG_W'($urandom_range(0, 400));
        dy = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 8191))
                                         : CFG_W'($urandom_range(0, 400));
        // mostly proper negative spans, now and then any bit pattern
        xn = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 8191))
                                         : CFG_W'(-int'($urandom_range(1, 4095)));
        yn = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 8191))
                                         : CFG_W'(-int'($urandom_range(1, 4095)));
        calibrate(cx, cy, dx, dy, xn, CFG_W'($urandom_range(0, 8191)),
                  yn, CFG_W'($urandom_range(0, 8191)));
    endtask

    // result checker and downstream backpressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word.x = m_tdata[12:0];
            got_word.y = m_tdata[25:13];
            if (pending_sticks.size() == 0) begin
                $error("word with nothing pending: out_x=%0d out_y=%0d",
                       $signed(got_word.x), $signed(got_word.y));
                errors++;
            end else begin
                want_word = pending_sticks.pop_front();
                if (got_word.x !== want_word.x) begin
                    $error("out_x expected %0d got %0d", $signed(want_word.x),
                           $signed(got_word.x));
                    errors++;
                end
                if (got_word.y !== want_word.y) begin
                    $error("out_y expected %0d got %0d", $signed(want_word.y),
                           $signed(got_word.y));
                    errors++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            ready_hold = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL joystick_axis_conditioner_unit");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_stick(directed_rows[i].op, directed_rows[i].raw_x, directed_rows[i].raw_y,
                       directed_rows[i].known, directed_rows[i].want_x,
                       directed_rows[i].want_y);

        // extremes: edge centers, widest deadzone, largest and smallest spans
        calibrate(13'd0, 13'd4095, 13'd4095, 13'd4095, -13'sd4095, 13'd4095, -13'sd1, 13'd1);
        send_random_sticks(70, 1'b0);

        // all divisors zero, no deadzone
        calibrate(13'd4095, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
        send_random_sticks(70, 1'b0);

        // negative-side spans of the wrong sign; top bit set on 12-bit registers
        calibrate(13'd2048, 13'h1800, 13'd300, 13'd50, 13'd4095, 13'h1FFF, 13'd17, 13'd900);
        send_random_sticks(70, 1'b0);

        for (int p = 0; p < 6; p++) begin
            random_calibration();
            if (p == 5)
                calm = 1'b1;
            send_random_sticks(70, p == 0);
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("PASS joystick_axis_conditioner_unit");
        else
            $display("FAIL joystick_axis_conditioner_unit");
        $finish;
    end

endmodule

FILE: sim.f
rtl/jac_pkg.sv
rtl/jac_prep.sv
rtl/jac_div_cell.sv
rtl/jac_skid.sv
rtl/joystick_axis_conditioner_unit.sv
tb/sv/testbench.sv
